### rtl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, constants and the CRC-16/Modbus byte update for the framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned CRC_LEN   = 6;
  localparam int unsigned CNT_W     = $clog2(FRAME_LEN);

  localparam logic        REQ_READ   = 1'b0;
  localparam logic        REQ_WRITE  = 1'b1;
  localparam logic [7:0]  FUNC_READ  = 8'h03;
  localparam logic [7:0]  FUNC_WRITE = 8'h06;
  localparam logic [15:0] READ_QTY   = 16'h0001;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam logic [CNT_W-1:0] CNT_CRC_LO = CNT_W'(CRC_LEN);
  localparam logic [CNT_W-1:0] CNT_CRC_HI = CNT_W'(CRC_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(FRAME_LEN - 1);

  typedef struct packed {
    logic [CRC_LEN-1:0][7:0] bytes;
    logic [CRC_LEN-1:0][7:0] pend;
    logic [15:0]             crc;
  } frame_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/mrf_req_if.sv
// ----------------------------------------------------------------------------
// mrf_req_if
// Request channel: one word is one framing request.
// ----------------------------------------------------------------------------
interface mrf_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  slave_addr;
  logic [15:0] reg_addr;
  logic [15:0] reg_value;

  modport source (output valid, req_type, slave_addr, reg_addr, reg_value, input ready);
  modport sink   (input valid, req_type, slave_addr, reg_addr, reg_value, output ready);
endinterface

### rtl/mrf_byte_if.sv
// ----------------------------------------------------------------------------
// mrf_byte_if
// Byte channel: one word is one frame byte with its last flag.
// ----------------------------------------------------------------------------
interface mrf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

### rtl/mrf_build.sv
// ----------------------------------------------------------------------------
// mrf_build
// Entry stage: lays out the six frame bytes and seeds the CRC.
// ----------------------------------------------------------------------------
module mrf_build (
  input  logic             clk_i,
  input  logic             rst_ni,
  mrf_req_if.sink          req_i,
  output logic             valid_o,
  input  logic             ready_i,
  output mrf_pkg::frame_t  data_o
);

  logic            valid_q;
  mrf_pkg::frame_t data_q, data_d;
  logic [15:0]     payload;

  assign req_i.ready = !valid_q || ready_i;

  always_comb begin
    payload = (req_i.req_type == mrf_pkg::REQ_WRITE) ? req_i.reg_value : mrf_pkg::READ_QTY;
    data_d.bytes[0] = req_i.slave_addr;
    data_d.bytes[1] = (req_i.req_type == mrf_pkg::REQ_WRITE) ? mrf_pkg::FUNC_WRITE
                                                             : mrf_pkg::FUNC_READ;
    data_d.bytes[2] = req_i.reg_addr[15:8];
    data_d.bytes[3] = req_i.reg_addr[7:0];
    data_d.bytes[4] = payload[15:8];
    data_d.bytes[5] = payload[7:0];
    data_d.pend     = data_d.bytes;
    data_d.crc      = mrf_pkg::CRC_INIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/mrf_crc_stage.sv
// ----------------------------------------------------------------------------
// mrf_crc_stage
// One CRC pipeline stage: folds the next pending byte into the CRC.
// ----------------------------------------------------------------------------
module mrf_crc_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  mrf_pkg::frame_t  data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output mrf_pkg::frame_t  data_o
);

  logic            valid_q;
  mrf_pkg::frame_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d       = data_i;
    data_d.crc   = mrf_pkg::crc_byte(data_i.crc, data_i.pend[0]);
    data_d.pend  = {8'h00, data_i.pend[mrf_pkg::CRC_LEN-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/mrf_serializer.sv
// ----------------------------------------------------------------------------
// mrf_serializer
// Holds one finished frame and sends it out one byte per word.
// ----------------------------------------------------------------------------
module mrf_serializer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  mrf_pkg::frame_t  data_i,
  mrf_byte_if.source       byte_o
);

  logic                      valid_q;
  logic [mrf_pkg::CNT_W-1:0] cnt_q, cnt_d;
  mrf_pkg::frame_t           data_q;
  logic                      out_fire;
  logic                      at_last;

  assign at_last  = (cnt_q == mrf_pkg::CNT_LAST);
  assign out_fire = valid_q && byte_o.ready;
  assign ready_o  = !valid_q || (out_fire && at_last);

  always_comb begin
    cnt_d = cnt_q;
    if (valid_i && ready_o) begin
      cnt_d = '0;
    end else if (out_fire) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (ready_o) begin
        valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  always_comb begin
    case (cnt_q)
      mrf_pkg::CNT_CRC_LO: byte_o.frame_byte = data_q.crc[7:0];
      mrf_pkg::CNT_CRC_HI: byte_o.frame_byte = data_q.crc[15:8];
      default:             byte_o.frame_byte = data_q.bytes[cnt_q[$clog2(mrf_pkg::CRC_LEN)-1:0]];
    endcase
  end

  assign byte_o.valid     = valid_q;
  assign byte_o.last_byte = at_last;

  a_load_starts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> valid_q && cnt_q == '0)
    else $error("new frame did not start at byte zero");

  a_stall_holds_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !byte_o.ready |=> valid_q && $stable(cnt_q))
    else $error("byte index moved while stalled");

  a_no_early_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && ready_o |-> at_last && byte_o.ready)
    else $error("frame buffer released before last byte");

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && at_last && !valid_i |=> !valid_q)
    else $error("serializer stayed busy after last byte");

endmodule

### rtl/modbus_rtu_request_framer.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer
// Path: build stage, six CRC stages (one byte each), serializer register.
// Build and CRC stages take a request every cycle unless the stage ahead
// stalls; the serializer takes a frame when empty or as its last byte leaves.
// Reset: asynchronous active low, empties all stages; no clearing pass.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrf_req_if.sink    req_i,
  mrf_byte_if.source byte_o
);

  localparam int unsigned N = mrf_pkg::CRC_LEN;

  logic            valid_s [N+1];
  logic            ready_s [N+1];
  mrf_pkg::frame_t data_s  [N+1];

  mrf_build u_build (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .data_o  (data_s[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_crc
    mrf_crc_stage u_crc (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .data_i  (data_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .data_o  (data_s[k+1])
    );
  end

  mrf_serializer u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[N]),
    .ready_o (ready_s[N]),
    .data_i  (data_s[N]),
    .byte_o  (byte_o)
  );

endmodule

### tb/mrf_frame_compare.sv
// ----------------------------------------------------------------------------
// mrf_frame_compare
// Watches the request and byte channels of the Modbus RTU request framer,
// builds the eight expected frame bytes for every accepted request (address,
// function code, register, value or quantity, CRC-16/Modbus low then high)
// and compares each accepted output word against the oldest pending byte.
// ----------------------------------------------------------------------------
module mrf_frame_compare (
  input  logic clk_i,
  input  logic rst_ni,
  mrf_req_if   req_mon,
  mrf_byte_if  byte_mon,
  output int   fail_count_o,
  output int   pending_bytes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_word_t;

  frame_word_t expected_bytes_q[$];
  int          mismatches = 0;

  function automatic logic [15:0] modbus_crc16(
      input logic [mrf_pkg::CRC_LEN-1:0][7:0] hdr);
    logic [15:0] acc;
    acc = mrf_pkg::CRC_INIT;
    for (int i = 0; i < mrf_pkg::CRC_LEN; i++) begin
      acc = acc ^ {8'h00, hdr[i]};
      for (int b = 0; b < 8; b++) begin
        acc = acc[0] ? ((acc >> 1) ^ mrf_pkg::CRC_POLY) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  function automatic void queue_frame(input logic rt, input logic [7:0] sa,
                                      input logic [15:0] ra, input logic [15:0] rv);
    logic [mrf_pkg::CRC_LEN-1:0][7:0] hdr;
    logic [15:0]                      payload;
    logic [15:0]                      crc;
    payload = (rt == mrf_pkg::REQ_WRITE) ? rv : mrf_pkg::READ_QTY;
    hdr[0]  = sa;
    hdr[1]  = (rt == mrf_pkg::REQ_WRITE) ? mrf_pkg::FUNC_WRITE : mrf_pkg::FUNC_READ;
    hdr[2]  = ra[15:8];
    hdr[3]  = ra[7:0];
    hdr[4]  = payload[15:8];
    hdr[5]  = payload[7:0];
    crc     = modbus_crc16(hdr);
    for (int k = 0; k < mrf_pkg::CRC_LEN; k++) begin
      expected_bytes_q.push_back('{frame_byte: hdr[k], last_byte: 1'b0});
    end
    expected_bytes_q.push_back('{frame_byte: crc[7:0], last_byte: 1'b0});
    expected_bytes_q.push_back('{frame_byte: crc[15:8], last_byte: 1'b1});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_word_t want;
    if (!rst_ni) begin
      expected_bytes_q.delete();
      pending_bytes_o <= 0;
      fail_count_o    <= mismatches;
    end else begin
      // byte first: a word leaving now always belongs to an earlier request
      if (byte_mon.valid && byte_mon.ready) begin
        if (expected_bytes_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual byte %02h last %0b",
                   $time, byte_mon.frame_byte, byte_mon.last_byte);
          mismatches++;
        end else begin
          want = expected_bytes_q.pop_front();
          if (byte_mon.frame_byte !== want.frame_byte) begin
            $display("%0t: frame_byte mismatch: expected %02h actual %02h",
                     $time, want.frame_byte, byte_mon.frame_byte);
            mismatches++;
          end
          if (byte_mon.last_byte !== want.last_byte) begin
            $display("%0t: last_byte mismatch: expected %0b actual %0b",
                     $time, want.last_byte, byte_mon.last_byte);
            mismatches++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        queue_frame(req_mon.req_type, req_mon.slave_addr, req_mon.reg_addr,
                    req_mon.reg_value);
      end
      pending_bytes_o <= expected_bytes_q.size();
      fail_count_o    <= mismatches;
    end
  end

endmodule

### tb/modbus_rtu_request_framer_tb.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_tb
// Drives framing requests in random bursts, directed corners first, while the
// byte sink stalls in changing patterns; a side module predicts and checks
// every frame byte. Ends with the verdict once all bytes have drained.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM  = 500;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending_bytes;
  int   cycle_count = 0;

  always #2 clk_i = ~clk_i;

  mrf_req_if  req_if ();
  mrf_byte_if byte_if ();

  modbus_rtu_request_framer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .byte_o (byte_if.source)
  );

  mrf_frame_compare frame_compare (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_mon         (req_if),
    .byte_mon        (byte_if),
    .fail_count_o    (fail_count),
    .pending_bytes_o (pending_bytes)
  );

  function automatic logic [15:0] pick_u16();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_u8();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  // drive one word at the falling edge, hold until accepted, return at the next falling edge
  task automatic send_request(input logic rt, input logic [7:0] sa,
                              input logic [15:0] ra, input logic [15:0] rv);
    req_if.valid      <= 1'b1;
    req_if.req_type   <= rt;
    req_if.slave_addr <= sa;
    req_if.reg_addr   <= ra;
    req_if.reg_value  <= rv;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drain_frames();
    req_if.valid <= 1'b0;
    while (pending_bytes != 0) @(negedge clk_i);
  endtask

  // byte sink stall patterns, switched when the phase counter wraps
  initial begin
    int stall_mode;
    int stall_left;
    int phase_cycles;
    stall_mode    = 0;
    stall_left    = 0;
    phase_cycles  = 0;
    byte_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (phase_cycles == 255) begin
        stall_mode = $urandom_range(0, 3);
      end
      phase_cycles = (phase_cycles + 1) % 256;
      case (stall_mode)
        0: byte_if.ready <= 1'b1;
        1: byte_if.ready <= 1'($urandom_range(0, 1));
        2: byte_if.ready <= ($urandom_range(0, 7) != 0);
        default: begin
          if (stall_left > 0) begin
            byte_if.ready <= 1'b0;
            stall_left--;
          end else begin
            byte_if.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int burst_len;
    req_if.valid      = 1'b0;
    req_if.req_type   = mrf_pkg::REQ_READ;
    req_if.slave_addr = 8'h00;
    req_if.reg_addr   = 16'h0000;
    req_if.reg_value  = 16'h0000;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // corners: both functions, extreme fields, reads with a nonzero value
    send_request(mrf_pkg::REQ_READ,  8'h00, 16'h0000, 16'h0000);
    send_request(mrf_pkg::REQ_WRITE, 8'h00, 16'h0000, 16'h0000);
    send_request(mrf_pkg::REQ_READ,  8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(mrf_pkg::REQ_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(mrf_pkg::REQ_READ,  8'h01, 16'h0000, 16'hFFFF);
    send_request(mrf_pkg::REQ_READ,  8'h11, 16'h006B, 16'h1234);
    send_request(mrf_pkg::REQ_WRITE, 8'h11, 16'h0001, 16'h0003);
    send_request(mrf_pkg::REQ_WRITE, 8'h80, 16'h8000, 16'h0001);
    send_request(mrf_pkg::REQ_WRITE, 8'h7F, 16'h7FFF, 16'h8000);
    send_request(mrf_pkg::REQ_READ,  8'hA5, 16'h5AA5, 16'hA55A);
    send_request(mrf_pkg::REQ_WRITE, 8'h5A, 16'hA55A, 16'h5AA5);
    send_request(mrf_pkg::REQ_WRITE, 8'h01, 16'h00FF, 16'hFF00);
    drain_frames();

    for (int n = 0; n < NUM_RANDOM; ) begin
      burst_len = $urandom_range(1, 10);
      for (int k = 0; k < burst_len && n < NUM_RANDOM; k++, n++) begin
        send_request(1'($urandom_range(0, 1)), pick_u8(), pick_u16(), pick_u16());
      end
      if (n >= NUM_RANDOM / 2 && n - burst_len < NUM_RANDOM / 2) begin
        drain_frames();
      end else if ($urandom_range(0, 3) != 0) begin
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end

    drain_frames();
    repeat (16) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
